// ----- sv/rsl_pkg.sv -----
`timescale 1ns / 1ps

package rsl_pkg;

  localparam int CENTER_W    = 14;
  localparam int SUM_W       = 16;
  localparam int RAD_W       = 2 * SUM_W;
  localparam int DQ_W        = 16;
  localparam int REM_W       = DQ_W + 2;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = DQ_W / SQRT_STAGES;
  localparam int FACTOR_W    = 17;
  localparam int FRAC_W      = 16;
  localparam int RECIP_W     = 22;
  localparam int PROD_W      = DQ_W + RECIP_W;
  localparam int RECIP_SHIFT = 21;

  localparam logic [7:0]          FAR_DIST     = 8'd160;
  localparam logic [SUM_W:0]      FAR_LIMIT_SQ = 17'd25600;
  localparam logic [FACTOR_W-1:0] FAR_FACTOR   = 17'd13107;
  localparam logic [FACTOR_W-1:0] ONE_Q16      = 17'd65536;
  // ceil(2^26 / 25): floor(dq * 32 / 25) == (dq * RECIP_25) >> 21 for dq below 2^16
  localparam logic [RECIP_W-1:0]  RECIP_25     = 22'd2684355;

  typedef enum logic {
    CFG_CENTER_X = 1'b0,
    CFG_CENTER_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DQ_W-1:0]  root;
  } sqrt_state_t;

  // One restoring digit of the integer square root: bring in two radicand bits,
  // try root*4+1 against the partial remainder.
  function automatic sqrt_state_t sqrt_step(sqrt_state_t st, logic [1:0] pair);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    sqrt_state_t      res;
    rem_sh = {st.rem[REM_W-3:0], pair};
    trial  = {st.root, 2'b01};
    if (rem_sh >= trial) begin
      res.rem  = rem_sh - trial;
      res.root = {st.root[DQ_W-2:0], 1'b1};
    end else begin
      res.rem  = rem_sh;
      res.root = {st.root[DQ_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ----- sv/rsl_sqrt.sv -----
`timescale 1ns / 1ps

module rsl_sqrt
  import rsl_pkg::*;
#(
  parameter int SIDE_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SUM_W-1:0]  in_sum,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DQ_W-1:0]   out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic              stg_valid [SQRT_STAGES];
  logic              stg_ready [SQRT_STAGES];
  sqrt_state_t       stg_state [SQRT_STAGES];
  logic [SUM_W-1:0]  stg_sum   [SQRT_STAGES];
  logic [SIDE_W-1:0] stg_side  [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic              prev_valid;
    sqrt_state_t       prev_state;
    logic [SUM_W-1:0]  prev_sum;
    logic [SIDE_W-1:0] prev_side;
    logic              next_ready;
    logic [RAD_W-1:0]  rad;
    sqrt_state_t       state_next;

    if (g == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_state = '0;
      assign prev_sum   = in_sum;
      assign prev_side  = in_side;
    end else begin : g_rest
      assign prev_valid = stg_valid[g-1];
      assign prev_state = stg_state[g-1];
      assign prev_sum   = stg_sum[g-1];
      assign prev_side  = stg_side[g-1];
    end

    if (g == SQRT_STAGES - 1) begin : g_last
      assign next_ready = out_ready;
    end else begin : g_mid
      assign next_ready = stg_ready[g+1];
    end

    assign stg_ready[g] = !stg_valid[g] || next_ready;
    assign rad          = {prev_sum, {(RAD_W - SUM_W){1'b0}}};

    always_comb begin
      state_next = prev_state;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        state_next = sqrt_step(state_next, rad[RAD_W-1-2*(g*SQRT_STEPS+j) -: 2]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[g] <= 1'b0;
      end else if (stg_ready[g]) begin
        stg_valid[g] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_ready[g]) begin
        stg_state[g] <= state_next;
        stg_sum[g]   <= prev_sum;
        stg_side[g]  <= prev_side;
      end
    end
  end

  assign in_ready  = stg_ready[0];
  assign out_valid = stg_valid[SQRT_STAGES-1];
  assign out_root  = stg_state[SQRT_STAGES-1].root;
  assign out_side  = stg_side[SQRT_STAGES-1];

endmodule

// ----- sv/radial_spotlight_luminance.sv -----
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// --------  ----------------------  ---------------------------
// pixel in  in_valid / in_ready     pixel_x, pixel_y, luma_in
// luma out  out_valid / out_ready   luma_out
// config    cfg_we (no wait)        cfg_addr, cfg_data
//
// Nine register stages: abs difference, squares and far test, four square-root
// stages of four digits each, reciprocal multiply, factor, luma multiply.
// One pixel per cycle sustained while out_ready stays high.
// Synchronous reset clears the valid bits and both center registers.
// A stall on out_ready holds each occupied stage with no empty stage ahead of it; empty stages keep filling.

module radial_spotlight_luminance
  import rsl_pkg::*;
#(
  parameter int COORD_WIDTH = 12,
  parameter int LUMA_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [CENTER_W-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] pixel_x,
  input  logic [COORD_WIDTH-1:0] pixel_y,
  input  logic [LUMA_WIDTH-1:0]  luma_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LUMA_WIDTH-1:0]  luma_out
);

  localparam int DIFF_W = ((COORD_WIDTH + 1 > CENTER_W) ? COORD_WIDTH + 1 : CENTER_W) + 1;
  localparam int SIDE_W = LUMA_WIDTH + 1;
  localparam int SCALE_W = LUMA_WIDTH + FACTOR_W;

  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: absolute differences
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic [DIFF_W-1:0]        abs_x;
  logic [DIFF_W-1:0]        abs_y;
  logic                     v1;
  logic                     rdy1;
  logic [DIFF_W-1:0]        dx1;
  logic [DIFF_W-1:0]        dy1;
  logic [LUMA_WIDTH-1:0]    luma1;

  assign diff_x = $signed({{(DIFF_W - COORD_WIDTH){1'b0}}, pixel_x})
                - $signed({{(DIFF_W - CENTER_W){center_x[CENTER_W-1]}}, center_x});
  assign diff_y = $signed({{(DIFF_W - COORD_WIDTH){1'b0}}, pixel_y})
                - $signed({{(DIFF_W - CENTER_W){center_y[CENTER_W-1]}}, center_y});
  assign abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
  assign abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

  // stage 2: squares on the low byte, far test
  logic                  v2;
  logic                  rdy2;
  logic [SUM_W-1:0]      sum2;
  logic                  far2;
  logic [LUMA_WIDTH-1:0] luma2;
  logic [SUM_W-1:0]      sq_x;
  logic [SUM_W-1:0]      sq_y;
  logic [SUM_W:0]        sum_sq;
  logic                  far_next;

  assign sq_x     = dx1[7:0] * dx1[7:0];
  assign sq_y     = dy1[7:0] * dy1[7:0];
  assign sum_sq   = {1'b0, sq_x} + {1'b0, sq_y};
  assign far_next = (dx1 > DIFF_W'(FAR_DIST)) || (dy1 > DIFF_W'(FAR_DIST))
                 || (sum_sq > FAR_LIMIT_SQ);

  // stages 3 to 6: square root
  logic                  sq_in_ready;
  logic                  sq_out_valid;
  logic [DQ_W-1:0]       sq_root;
  logic [SIDE_W-1:0]     sq_side;

  // stage 7: reciprocal multiply
  logic                  v7;
  logic                  rdy7;
  logic [PROD_W-1:0]     prod7;
  logic                  far7;
  logic [LUMA_WIDTH-1:0] luma7;

  // stage 8: factor
  logic                  v8;
  logic                  rdy8;
  logic [FACTOR_W-1:0]   factor8;
  logic [LUMA_WIDTH-1:0] luma8;

  // stage 9: output register
  logic                  rdy9;
  logic [SCALE_W-1:0]    scaled;

  assign rdy9     = !out_valid || out_ready;
  assign rdy8     = !v8 || rdy9;
  assign rdy7     = !v7 || rdy8;
  assign rdy2     = !v2 || sq_in_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy7) v7 <= sq_out_valid;
      if (rdy8) v8 <= v7;
      if (rdy9) out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1   <= abs_x;
      dy1   <= abs_y;
      luma1 <= luma_in;
    end
    if (rdy2) begin
      sum2  <= sum_sq[SUM_W-1:0];
      far2  <= far_next;
      luma2 <= luma1;
    end
  end

  rsl_sqrt #(
    .SIDE_W(SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (sq_in_ready),
    .in_sum    (sum2),
    .in_side   ({far2, luma2}),
    .out_valid (sq_out_valid),
    .out_ready (rdy7),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign scaled = SCALE_W'(luma8) * SCALE_W'(factor8);

  always_ff @(posedge clk) begin
    if (rdy7) begin
      prod7 <= PROD_W'(sq_root) * PROD_W'(RECIP_25);
      far7  <= sq_side[SIDE_W-1];
      luma7 <= sq_side[LUMA_WIDTH-1:0];
    end
    if (rdy8) begin
      factor8 <= far7 ? FAR_FACTOR : ONE_Q16 - prod7[PROD_W-1:RECIP_SHIFT];
      luma8   <= luma7;
    end
    if (rdy9) begin
      luma_out <= scaled[LUMA_WIDTH+FRAC_W-1:FRAC_W];
    end
  end

endmodule
